@@ src/lkv_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
// Used by lkv_cell and lru_key_value_cache_core; depends on nothing.
`default_nettype none

package lkv_pkg;

  localparam int DATA_W = 32;           // width of key, write_value, read_value ports
  localparam int CFG_W  = 5;            // width of the capacity register
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  // Update applied across the row of cells.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_HIT,
    OP_FILL,
    OP_EVICT
  } op_t;

  typedef struct packed {
    logic capture;    // latch match / free / victim flags this cycle
    op_t  op;         // update to apply this cycle
    logic write_val;  // request carries a value to store
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic match;
  } cell_stat_t;

endpackage

`default_nettype wire

@@ src/lkv_cell.sv @@
// One cache entry: key, value, valid bit and recency rank.
// Passes hit and free-slot chains to its neighbor; uses lkv_pkg.
`default_nettype none

module lkv_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int RANK_W     = 4,
  parameter int CNT_W      = 5
) (
  input  wire                      clk,
  input  wire                      rst,
  input  lkv_pkg::cmd_t            cmd,
  input  wire [KEY_BITS-1:0]       req_key,
  input  wire [VALUE_BITS-1:0]     req_value,
  input  wire [CNT_W-1:0]          old_rank,
  input  wire [CNT_W-1:0]          last_rank,
  input  wire                      hit_in,
  input  wire [CNT_W-1:0]          rank_in,
  input  wire [VALUE_BITS-1:0]     value_in,
  input  wire                      free_in,
  output logic                     hit_out,
  output logic [CNT_W-1:0]         rank_out,
  output logic [VALUE_BITS-1:0]    value_out,
  output logic                     free_out,
  output lkv_pkg::cell_stat_t      stat
);
  import lkv_pkg::*;

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  valid;
  logic [RANK_W-1:0]     rank;
  logic                  match_q;
  logic                  free_q;
  logic                  victim_q;

  logic match;
  logic free_pick;
  logic victim;
  logic target;

  assign match     = valid && (key_q == req_key);
  assign free_pick = !valid && !free_in;
  assign victim    = valid && (CNT_W'(rank) == last_rank);

  assign hit_out   = hit_in | match;
  assign rank_out  = rank_in | (match ? CNT_W'(rank) : '0);
  assign value_out = value_in | (match ? value_q : '0);
  assign free_out  = free_in | !valid;

  assign stat.valid = valid;
  assign stat.match = match_q;

  always_comb begin
    case (cmd.op)
      OP_HIT:   target = match_q;
      OP_FILL:  target = free_q;
      OP_EVICT: target = victim_q;
      default:  target = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      rank     <= '0;
      match_q  <= 1'b0;
      free_q   <= 1'b0;
      victim_q <= 1'b0;
    end else begin
      if (cmd.capture) begin
        match_q  <= match;
        free_q   <= free_pick;
        victim_q <= victim;
      end
      if (target) begin
        rank <= '0;
        if (cmd.op == OP_FILL) begin
          valid <= 1'b1;
        end
      end else if (cmd.op != OP_NONE && valid && CNT_W'(rank) < old_rank) begin
        // age every entry that was more recent than the promoted one
        rank <= rank + 1'b1;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (target) begin
      if (cmd.write_val) begin
        value_q <= req_value;
      end
      if (cmd.op == OP_FILL || cmd.op == OP_EVICT) begin
        key_q <= req_key;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/lru_key_value_cache_core.sv @@
// Top level of the fully associative LRU key/value cache.
// Row of lkv_cell entries plus request control; uses lkv_pkg.
//
//   channel  direction  handshake               payload
//   in       into       in_valid / in_stall     req_type, key, write_value
//   out      out of     out_valid / out_stall   status, read_value
//   cfg      into       cfg_we                  cfg_wdata (capacity_in_use)
//
// Each request passes through a match cycle (key compare in every cell, hit and
// free-slot chains through the row) and an update cycle (rank aging, write).
// The next request is taken at the edge that ends the update cycle.
// The result sits in an output register; the update cycle holds while that
// register is full and stalled. Reset is synchronous and empties the cache.
`default_nettype none

module lru_key_value_cache_core #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                req_type,
  input  wire signed [lkv_pkg::DATA_W-1:0]   key,
  input  wire signed [lkv_pkg::DATA_W-1:0]   write_value,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               status,
  output logic signed [lkv_pkg::DATA_W-1:0]  read_value,
  input  wire                                cfg_we,
  input  wire [lkv_pkg::CFG_W-1:0]           cfg_wdata
);
  import lkv_pkg::*;

  localparam int RANK_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  state_t state, state_next;

  logic [CFG_W-1:0]      capacity_in_use;
  logic [CNT_W-1:0]      used_count;

  logic                  req_set;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  logic                  hit_any;
  logic [CNT_W-1:0]      hit_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  free_any;

  logic                  accept;
  logic                  upd_fire;
  logic                  fill_ok;
  cmd_t                  cmd;
  logic [CNT_W-1:0]      old_rank;
  logic [CNT_W-1:0]      last_rank;
  logic [CMP_W-1:0]      cap_wide;
  logic [CMP_W-1:0]      cap_active;

  logic                  hit_c   [CAPACITY+1];
  logic [CNT_W-1:0]      rank_c  [CAPACITY+1];
  logic [VALUE_BITS-1:0] value_c [CAPACITY+1];
  logic                  free_c  [CAPACITY+1];
  cell_stat_t            stat    [CAPACITY];
  logic [CAPACITY-1:0]   valid_vec;
  logic [CAPACITY-1:0]   match_vec;

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    upd_fire   = 1'b0;
    in_stall   = 1'b1;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_MATCH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        upd_fire = !out_valid || !out_stall;
        in_stall = !upd_fire;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    accept = in_valid && !in_stall;
    if (accept) begin
      state_next = ST_MATCH;
    end else if (upd_fire) begin
      state_next = ST_IDLE;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_in_use <= cfg_wdata;
    end
  end

  // clamp to 1 .. CAPACITY
  always_comb begin
    cap_wide = CMP_W'(capacity_in_use);
    if (cap_wide == '0) begin
      cap_active = CMP_W'(1);
    end else if (cap_wide > CMP_W'(CAPACITY)) begin
      cap_active = CMP_W'(CAPACITY);
    end else begin
      cap_active = cap_wide;
    end
  end

  assign fill_ok   = CMP_W'(used_count) < cap_active;
  assign last_rank = used_count - 1'b1;

  // ---------------- request register ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      req_set   <= req_type;
      req_key   <= KEY_BITS'(key);
      req_value <= VALUE_BITS'(write_value);
    end
  end

  // ---------------- cell command ----------------
  always_comb begin
    cmd.capture   = (state == ST_MATCH);
    cmd.write_val = req_set;
    cmd.op        = OP_NONE;
    old_rank      = hit_rank;
    if (upd_fire) begin
      if (hit_any) begin
        cmd.op = OP_HIT;
      end else if (req_set && fill_ok) begin
        cmd.op   = OP_FILL;
        old_rank = used_count;
      end else if (req_set) begin
        cmd.op   = OP_EVICT;
        old_rank = last_rank;
      end
    end
  end

  // ---------------- row of cells ----------------
  assign hit_c[0]   = 1'b0;
  assign rank_c[0]  = '0;
  assign value_c[0] = '0;
  assign free_c[0]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lkv_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .RANK_W     (RANK_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .req_key   (req_key),
      .req_value (req_value),
      .old_rank  (old_rank),
      .last_rank (last_rank),
      .hit_in    (hit_c[i]),
      .rank_in   (rank_c[i]),
      .value_in  (value_c[i]),
      .free_in   (free_c[i]),
      .hit_out   (hit_c[i+1]),
      .rank_out  (rank_c[i+1]),
      .value_out (value_c[i+1]),
      .free_out  (free_c[i+1]),
      .stat      (stat[i])
    );
    assign valid_vec[i] = stat[i].valid;
    assign match_vec[i] = stat[i].match;
  end

  // capture the chain ends at the close of the match cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_any  <= 1'b0;
      free_any <= 1'b0;
    end else if (state == ST_MATCH) begin
      hit_any  <= hit_c[CAPACITY];
      free_any <= free_c[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MATCH) begin
      hit_rank  <= rank_c[CAPACITY];
      hit_value <= value_c[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (cmd.op == OP_FILL) begin
      used_count <= used_count + 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      status     <= !req_set && !hit_any;
      read_value <= (!req_set && hit_any) ? DATA_W'(hit_value) : '0;
    end
  end

  // ---------------- assertions ----------------
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(used_count))
    else $error("valid entry count differs from used_count");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> $onehot0(match_vec))
    else $error("key matched in more than one entry");

  a_fill_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FILL |-> free_any)
    else $error("fill with no free entry");

  a_update_order: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_MATCH ##1 state == ST_UPDATE)
    else $error("request skipped the match cycle");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(upd_fire))
    else $error("result appeared without an update");

endmodule

`default_nettype wire

@@ tb/tb_lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps
// Testbench for lru_key_value_cache_core: directed and random get/set requests
// checked against an LRU cache predictor kept in the bench.
// Depends on lkv_pkg and the cache RTL only.

module tb_lru_key_value_cache_core;
  import lkv_pkg::*;

  localparam int   SLOTS      = 16;
  localparam int   IDLE_LIMIT = 4000;
  localparam logic REQ_GET    = 1'b0;
  localparam logic REQ_SET    = 1'b1;
  localparam logic RESP_OK    = 1'b0;
  localparam logic RESP_MISS  = 1'b1;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] value;
  } lookup_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     req_type = 1'b0;
  logic signed [DATA_W-1:0] key = '0;
  logic signed [DATA_W-1:0] write_value = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic                     status;
  logic signed [DATA_W-1:0] read_value;

  // Predictor state
  logic [DATA_W-1:0] slot_key [SLOTS];
  logic [DATA_W-1:0] slot_value [SLOTS];
  logic              slot_valid [SLOTS];
  int unsigned       slot_rank [SLOTS];
  int unsigned       fill_count;
  logic [CFG_W-1:0]  capacity_reg;

  lookup_result_t expected_results[$];
  int error_count = 0;
  int send_gap_max = 6;
  int stall_max = 6;
  int stall_left = 0;
  int idle_cycles = 0;

  lru_key_value_cache_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .key        (key),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .read_value (read_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int effective_capacity(input logic [CFG_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > SLOTS) return SLOTS;
    return int'(cap);
  endfunction

  // Age every valid entry that was more recent than old_rank, then put s in front.
  function automatic void make_most_recent(input int s, input int unsigned old_rank);
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic lookup_result_t cache_lookup(input logic is_set,
                                                  input logic [DATA_W-1:0] k,
                                                  input logic [DATA_W-1:0] v);
    lookup_result_t r;
    int hit;
    int slot;
    int victim;
    int unsigned worst;
    r.status = RESP_OK;
    r.value = '0;
    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && slot_valid[i] && slot_key[i] == k) hit = i;
    if (is_set == REQ_GET) begin
      if (hit < 0) begin
        r.status = RESP_MISS;
      end else begin
        make_most_recent(hit, slot_rank[hit]);
        r.value = slot_value[hit];
      end
      return r;
    end
    if (hit >= 0) begin
      slot_value[hit] = v;
      make_most_recent(hit, slot_rank[hit]);
      return r;
    end
    // Fill the lowest free slot while room remains, else replace the oldest.
    slot = -1;
    if (fill_count < effective_capacity(capacity_reg))
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && !slot_valid[i]) slot = i;
    if (slot >= 0) begin
      slot_valid[slot] = 1'b1;
      slot_key[slot] = k;
      slot_value[slot] = v;
      slot_rank[slot] = fill_count;
      make_most_recent(slot, fill_count);
      fill_count++;
      return r;
    end
    victim = -1;
    worst = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && (victim < 0 || slot_rank[i] > worst)) begin
        victim = i;
        worst = slot_rank[i];
      end
    if (victim >= 0) begin
      slot_key[victim] = k;
      slot_value[victim] = v;
      make_most_recent(victim, worst);
    end
    return r;
  endfunction

  // Leaves in_valid high so a back-to-back request needs no extra edge.
  task automatic send_request(input logic kind, input logic [DATA_W-1:0] k,
                              input logic [DATA_W-1:0] v);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    key <= k;
    write_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(cache_lookup(kind, k, v));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] cap);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    capacity_reg = cap;
    cfg_we <= 1'b0;
  endtask

  task automatic test_basic_access();
    send_request(REQ_GET, 32'h8000_0000, 32'h7fff_ffff);
    send_request(REQ_SET, 32'h8000_0000, 32'h7fff_ffff);
    send_request(REQ_SET, 32'h7fff_ffff, 32'h8000_0000);
    send_request(REQ_SET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_SET, 32'hffff_ffff, 32'hffff_ffff);
    send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0000, 32'hffff_ffff);
    send_request(REQ_GET, 32'hffff_ffff, 32'hffff_ffff);
    send_request(REQ_SET, 32'h7fff_ffff, 32'h1234_5678);
    send_request(REQ_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
  endtask

  // Zero acts as one entry, values above the array act as full size, and
  // shrinking below the fill keeps old entries while a miss replaces the oldest.
  task automatic test_capacity_extremes();
    set_capacity(5'd0);
    send_request(REQ_SET, 32'ha5a5_a5a5, 32'h0000_0001);
    send_request(REQ_GET, 32'ha5a5_a5a5, 32'h0000_0000);
    send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(REQ_SET, 32'h5a5a_5a5a, 32'h0000_0002);
    set_capacity(5'd31);
    send_request(REQ_SET, 32'h0000_0100, 32'hdead_beef);
    send_request(REQ_SET, 32'h0000_0200, 32'h0bad_f00d);
    send_request(REQ_GET, 32'ha5a5_a5a5, 32'h0000_0000);
    set_capacity(5'd1);
    send_request(REQ_SET, 32'h0000_0300, 32'h5555_aaaa);
  endtask

  // Draw keys from a pool a little larger than the capacity so hits,
  // overwrites and replacements all happen often.
  task automatic test_random_traffic(input int count, input logic [CFG_W-1:0] cap,
                                     input bit no_idle);
    logic [DATA_W-1:0] pool [24];
    logic [DATA_W-1:0] k;
    logic kind;
    int pool_size;
    set_capacity(cap);
    send_gap_max = no_idle ? 0 : 6;
    stall_max = no_idle ? 0 : 6;
    pool_size = effective_capacity(cap) + $urandom_range(1, 6);
    if (pool_size > 24) pool_size = 24;
    for (int i = 0; i < 24; i++) pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 15) == 0) k = $urandom;
      else k = pool[$urandom_range(0, pool_size - 1)];
      kind = ($urandom_range(0, 1) == 1) ? REQ_SET : REQ_GET;
      send_request(kind, k, $urandom);
    end
    send_gap_max = 6;
    stall_max = 6;
  endtask

  // Check each result and draw the stall ahead of the next one.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0d read_value %h",
                 $time, status, read_value);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
          error_count++;
        end
        if (read_value !== want.value) begin
          $display("%0t: read_value expected %h, actual %h",
                   $time, want.value, read_value);
          error_count++;
        end
      end
      stall_left = $urandom_range(0, stall_max);
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    capacity_reg = CAP_RESET;
    fill_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_rank[i] = 0;
      slot_key[i] = '0;
      slot_value[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_basic_access();
    test_capacity_extremes();
    test_random_traffic(216, 5'd16, 1'b0);
    test_random_traffic(216, 5'd1, 1'b0);
    test_random_traffic(216, 5'd31, 1'b1);
    test_random_traffic(216, 5'd0, 1'b0);
    test_random_traffic(216, 5'd2, 1'b0);
    test_random_traffic(216, 5'd5, 1'b1);
    test_random_traffic(216, 5'($urandom_range(0, 31)), 1'b0);
    test_random_traffic(216, 5'd16, 1'b0);
    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lkv_pkg.sv
src/lkv_cell.sv
src/lru_key_value_cache_core.sv
tb/tb_lru_key_value_cache_core.sv
